// File: design/windowed_trend_t_statistic_top_defines.svh
// Assertion macros used by the checker file of the trend t-statistic block.
`ifndef WINDOWED_TREND_T_STATISTIC_TOP_DEFINES_SVH
`define WINDOWED_TREND_T_STATISTIC_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define WTS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off while reset is high.
`define WTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Condition that must hold in the cycle after reset.
`define WTS_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/wts_pkg.sv
// Shared constants, codes and types of the trend t-statistic block.
package wts_pkg;

  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int LEN_RESET       = 64;
  localparam int LEN_MIN         = 3;
  localparam int SAMPLE_W        = 24;
  localparam int LEN_CFG_W       = 7;
  localparam int T_W             = 32;
  localparam int WORD_W          = 64;
  localparam int WIDE_W          = 128;
  localparam int DIV_STEPS       = 160;
  localparam int SQRT_STEPS      = 32;

  typedef enum logic [1:0] {
    ALU_SUB,
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUMS,
    S_ISSUE,
    S_WAIT,
    S_FINISH
  } seq_state_t;

  typedef enum logic [4:0] {
    ST_D1, ST_D2, ST_D3,
    ST_Q1, ST_Q2, ST_Q3,
    ST_B1, ST_B2, ST_B3,
    ST_A1, ST_A2, ST_A3,
    ST_R1, ST_R2, ST_R3,
    ST_N1, ST_N2, ST_N3, ST_N4, ST_N5, ST_N6,
    ST_S1, ST_S2, ST_S3
  } calc_step_t;

endpackage

// File: design/wts_alu.sv
// Shared iterative unit: subtract, shift-add multiply, restoring divide, integer square root.
module wts_alu (
  input  logic                            clk,
  input  logic                            rst,
  input  wts_pkg::alu_req_t               req,
  input  logic [wts_pkg::WIDE_W-1:0]      a,
  input  logic [wts_pkg::WIDE_W-1:0]      b,
  output logic [wts_pkg::WIDE_W-1:0]      res,
  output logic                            done
);

  localparam int W     = wts_pkg::WIDE_W;
  localparam int WW    = wts_pkg::WORD_W;
  localparam int CNT_W = $clog2(wts_pkg::DIV_STEPS + 1);

  logic                busy;
  wts_pkg::alu_op_t    op_r;
  logic [W-1:0]        acc;
  logic [W-1:0]        x;
  logic [W-1:0]        y;
  logic [WW-1:0]       quo;
  logic                sat;
  logic [CNT_W-1:0]    cnt;

  logic [W:0]          add_l, add_r, add_sum;
  logic                add_inv;
  logic                no_borrow;
  logic [W-1:0]        remsh;
  logic [WW-1:0]       sq_res, sq_bit;

  // single adder shared by every operation; on a subtract the top bit of the
  // difference flags a borrow
  always_comb begin
    remsh  = {acc[W-2:0], x[W-1]};
    sq_res = acc[WW-1:0];
    sq_bit = y[WW-1:0];
    add_l   = {1'b0, acc};
    add_r   = {1'b0, x};
    add_inv = 1'b0;
    case (op_r)
      wts_pkg::ALU_SUB: begin
        add_inv = 1'b1;
      end
      wts_pkg::ALU_MUL: begin
        add_inv = 1'b0;
      end
      wts_pkg::ALU_DIV: begin
        add_l   = {1'b0, remsh};
        add_r   = {1'b0, y};
        add_inv = 1'b1;
      end
      wts_pkg::ALU_SQRT: begin
        add_l   = {1'b0, x};
        add_r   = (W+1)'(sq_res | sq_bit);
        add_inv = 1'b1;
      end
      default: begin
        add_inv = 1'b0;
      end
    endcase
    add_sum   = add_l + (add_inv ? ~add_r : add_r) + {{W{1'b0}}, add_inv};
    no_borrow = ~add_sum[W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      op_r <= wts_pkg::ALU_SUB;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op_r <= req.op;
        case (req.op)
          wts_pkg::ALU_SUB: begin
            acc <= a;
            x   <= b;
          end
          wts_pkg::ALU_MUL: begin
            acc <= '0;
            x   <= a;
            y   <= b;
          end
          wts_pkg::ALU_DIV: begin
            acc <= '0;
            x   <= a;
            y   <= b;
            quo <= '0;
            sat <= 1'b0;
            cnt <= CNT_W'(wts_pkg::DIV_STEPS);
          end
          wts_pkg::ALU_SQRT: begin
            acc <= '0;
            x   <= W'(a[WW-1:0]);
            y   <= W'(1) << (WW - 2);
            cnt <= CNT_W'(wts_pkg::SQRT_STEPS);
          end
          default: begin
            acc <= '0;
          end
        endcase
      end else if (busy) begin
        case (op_r)
          wts_pkg::ALU_SUB: begin
            acc  <= add_sum[W-1:0];
            busy <= 1'b0;
            done <= 1'b1;
          end
          wts_pkg::ALU_MUL: begin
            // stops once the multiplier runs out of set bits
            if (y == '0) begin
              busy <= 1'b0;
              done <= 1'b1;
            end else begin
              if (y[0]) begin
                acc <= add_sum[W-1:0];
              end
              x <= x << 1;
              y <= y >> 1;
            end
          end
          wts_pkg::ALU_DIV: begin
            x <= x << 1;
            if (quo[WW-1]) begin
              sat <= 1'b1;
            end
            quo <= {quo[WW-2:0], no_borrow};
            acc <= no_borrow ? add_sum[W-1:0] : remsh;
            cnt <= cnt - CNT_W'(1);
            if (cnt == CNT_W'(1)) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          wts_pkg::ALU_SQRT: begin
            if (no_borrow) begin
              x   <= W'(add_sum[WW-1:0]);
              acc <= W'((sq_res >> 1) + sq_bit);
            end else begin
              acc <= W'(sq_res >> 1);
            end
            y   <= y >> 2;
            cnt <= cnt - CNT_W'(1);
            if (cnt == CNT_W'(1)) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          default: begin
            busy <= 1'b0;
          end
        endcase
      end
    end
  end

  always_comb begin
    case (op_r)
      wts_pkg::ALU_DIV: res = sat ? W'({WW{1'b1}}) : W'(quo);
      default:          res = acc;
    endcase
  end

endmodule

// File: design/wts_window.sv
// Circular sample store and the sweep that forms the window sums.
module wts_window #(
  parameter int WINDOW_MAX  = wts_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = wts_pkg::SAMPLE_BITS_DEF,
  parameter int LEN_W       = $clog2(WINDOW_MAX + 1)
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   clear,
  input  logic [LEN_W-1:0]                       len,
  input  logic                                   wr_en,
  input  logic signed [SAMPLE_BITS-1:0]          wr_data,
  output logic                                   will_fill,
  output logic signed [SAMPLE_BITS+LEN_W-1:0]    sum_y,
  output logic signed [SAMPLE_BITS+2*LEN_W-1:0]  sum_xy,
  output logic signed [2*SAMPLE_BITS+LEN_W-1:0]  sum_yy,
  output logic [2*LEN_W-1:0]                     sum_x,
  output logic [3*LEN_W-1:0]                     sum_xx,
  output logic                                   sums_done
);

  localparam int IDX_W = $clog2(WINDOW_MAX);
  localparam int SY_W  = SAMPLE_BITS + LEN_W;
  localparam int SXY_W = SAMPLE_BITS + 2*LEN_W;
  localparam int SYY_W = 2*SAMPLE_BITS + LEN_W;
  localparam int PXY_W = SAMPLE_BITS + LEN_W + 1;

  logic signed [SAMPLE_BITS-1:0] mem [WINDOW_MAX];

  logic [IDX_W-1:0] widx, widx_inc;
  logic [LEN_W-1:0] fill;
  logic [LEN_W:0]   wi, nl, st_full;
  logic [IDX_W-1:0] start_idx;

  logic             run;
  logic [IDX_W-1:0] ridx;
  logic [LEN_W-1:0] k;

  logic signed [SAMPLE_BITS-1:0]   rd_v;
  logic [LEN_W-1:0]                rd_k;
  logic                            rd_vld, rd_last;
  logic signed [2*SAMPLE_BITS-1:0] p_yy;
  logic signed [PXY_W-1:0]         p_xy;
  logic [2*LEN_W-1:0]              p_kk;
  logic signed [SAMPLE_BITS-1:0]   p_v;
  logic [LEN_W-1:0]                p_k;
  logic                            p_vld, p_last;

  always_comb begin
    widx_inc  = (widx == IDX_W'(WINDOW_MAX - 1)) ? '0 : widx + IDX_W'(1);
    will_fill = (({1'b0, fill} + (LEN_W+1)'(1)) >= {1'b0, len});
    // oldest sample sits len places behind the new write pointer
    wi        = (LEN_W+1)'(widx_inc);
    nl        = {1'b0, len};
    st_full   = (wi >= nl) ? wi - nl : wi + (LEN_W+1)'(WINDOW_MAX) - nl;
    start_idx = st_full[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[widx] <= wr_data;
    end
    if (run) begin
      rd_v <= mem[ridx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      widx      <= '0;
      fill      <= '0;
      run       <= 1'b0;
      rd_vld    <= 1'b0;
      p_vld     <= 1'b0;
      sums_done <= 1'b0;
    end else begin
      sums_done <= 1'b0;
      if (wr_en) begin
        widx <= widx_inc;
        if (fill < len) begin
          fill <= fill + LEN_W'(1);
        end
        if (will_fill) begin
          run    <= 1'b1;
          ridx   <= start_idx;
          k      <= LEN_W'(1);
          sum_y  <= '0;
          sum_xy <= '0;
          sum_yy <= '0;
          sum_x  <= '0;
          sum_xx <= '0;
        end
      end
      // stage 1: memory read
      rd_vld <= run;
      if (run) begin
        rd_k    <= k;
        rd_last <= (k == len);
        ridx    <= (ridx == IDX_W'(WINDOW_MAX - 1)) ? '0 : ridx + IDX_W'(1);
        k       <= k + LEN_W'(1);
        if (k == len) begin
          run <= 1'b0;
        end
      end
      // stage 2: products
      p_vld <= rd_vld;
      if (rd_vld) begin
        p_yy   <= rd_v * rd_v;
        p_xy   <= $signed({1'b0, rd_k}) * rd_v;
        p_kk   <= rd_k * rd_k;
        p_v    <= rd_v;
        p_k    <= rd_k;
        p_last <= rd_last;
      end
      // stage 3: accumulate
      if (p_vld) begin
        sum_y     <= sum_y + SY_W'(p_v);
        sum_xy    <= sum_xy + SXY_W'(p_xy);
        sum_yy    <= sum_yy + SYY_W'(p_yy);
        sum_x     <= sum_x + (2*LEN_W)'(p_k);
        sum_xx    <= sum_xx + (3*LEN_W)'(p_kk);
        sums_done <= p_last;
      end
    end
  end

endmodule

// File: design/windowed_trend_t_statistic_top.sv
// Top level of the sliding-window trend t-statistic block.
// Each input item is one signed Q16.8 sample. The block keeps the last window_len samples and,
// once the window is full, fits y = a + b*x (x = 1 oldest .. window_len newest) by least
// squares and returns one result item with |a|/se(a) and |b|/se(b) as unsigned Q16.16,
// saturated at all ones; a zero residual sets perfect_fit and forces both t-values to all
// ones. Until the window is full a sample causes no result and the block is ready again in
// the next cycle. With a full window an item is accepted, the sweep forms the sums, 24 steps
// run on the shared unit (fewer when the residual is zero) and the result is handed to the
// output register; no new sample is accepted until then. Each step is issued to the unit
// and then waits for its run; a multiply ends once its multiplier has no set bits left. The
// pace of an item is set by the single iterative arithmetic unit, which handles every
// multiply, subtract, divide and root in turn, and by the one read port of the sample memory
// during the sweep. A finished result waits in the output register while the next sample is
// accepted. Writing window_len clamps it into 3..WINDOW_MAX and empties the window; no
// clearing pass is needed.
module windowed_trend_t_statistic_top #(
  parameter int WINDOW_MAX  = wts_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = wts_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [wts_pkg::LEN_CFG_W-1:0]      cfg_wdata,      // window_len
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [wts_pkg::SAMPLE_W-1:0]       s_axis_tdata,   // sample
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [2*wts_pkg::T_W-1:0]          m_axis_tdata,   // intercept_t, slope_t
  output logic                               m_axis_tuser    // perfect_fit
);

  localparam int LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int SY_W  = SAMPLE_BITS + LEN_W;
  localparam int SXY_W = SAMPLE_BITS + 2*LEN_W;
  localparam int SYY_W = 2*SAMPLE_BITS + LEN_W;
  localparam int CMP_W = (LEN_W > wts_pkg::LEN_CFG_W) ? LEN_W : wts_pkg::LEN_CFG_W;
  localparam int W     = wts_pkg::WIDE_W;
  localparam int WW    = wts_pkg::WORD_W;
  localparam int TW    = wts_pkg::T_W;
  localparam int LEN_RST = (wts_pkg::LEN_RESET < WINDOW_MAX) ? wts_pkg::LEN_RESET : WINDOW_MAX;

  // window length register, clamped on write
  logic [LEN_W-1:0] len, len_next;
  logic [CMP_W-1:0] cfg_v;

  always_comb begin
    cfg_v = CMP_W'(cfg_wdata);
    if (cfg_v < CMP_W'(wts_pkg::LEN_MIN)) begin
      len_next = LEN_W'(wts_pkg::LEN_MIN);
    end else if (cfg_v > CMP_W'(WINDOW_MAX)) begin
      len_next = LEN_W'(WINDOW_MAX);
    end else begin
      len_next = LEN_W'(cfg_v);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= LEN_W'(LEN_RST);
    end else if (cfg_we) begin
      len <= len_next;
    end
  end

  // sample store and window sums
  logic                     in_acc;
  logic                     will_fill;
  logic signed [SY_W-1:0]   sum_y;
  logic signed [SXY_W-1:0]  sum_xy;
  logic signed [SYY_W-1:0]  sum_yy;
  logic [2*LEN_W-1:0]       sum_x;
  logic [3*LEN_W-1:0]       sum_xx;
  logic                     sums_done;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  wts_window #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS),
    .LEN_W       (LEN_W)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .clear     (cfg_we),
    .len       (len),
    .wr_en     (in_acc),
    .wr_data   ($signed(s_axis_tdata[SAMPLE_BITS-1:0])),
    .will_fill (will_fill),
    .sum_y     (sum_y),
    .sum_xy    (sum_xy),
    .sum_yy    (sum_yy),
    .sum_x     (sum_x),
    .sum_xx    (sum_xx),
    .sums_done (sums_done)
  );

  // shared arithmetic unit
  wts_pkg::alu_req_t alu_req;
  logic [W-1:0]      alu_a, alu_b, alu_res;
  logic              alu_done;

  wts_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .req  (alu_req),
    .a    (alu_a),
    .b    (alu_b),
    .res  (alu_res),
    .done (alu_done)
  );

  // sequencer
  wts_pkg::seq_state_t state, state_next;
  wts_pkg::calc_step_t step;

  logic [WW-1:0] d, q, b2, a2;
  logic [W-1:0]  r, b2sq, t0, t1;
  logic [TW-1:0] it_res, sl_res;
  logic          perfect;
  logic          out_free;
  logic          last_step, fit_zero;
  logic [SY_W-1:0] abs_y;
  logic [W-1:0]  n_w, nm2_w;
  logic [WW-1:0] res_abs;

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign fit_zero  = (step == wts_pkg::ST_R3) && (alu_res == '0);
  assign last_step = (step == wts_pkg::ST_S3) || fit_zero;

  always_comb begin
    state_next = state;
    case (state)
      wts_pkg::S_IDLE: begin
        if (in_acc && will_fill) begin
          state_next = wts_pkg::S_SUMS;
        end
      end
      wts_pkg::S_SUMS: begin
        if (sums_done) begin
          state_next = wts_pkg::S_ISSUE;
        end
      end
      wts_pkg::S_ISSUE: begin
        state_next = wts_pkg::S_WAIT;
      end
      wts_pkg::S_WAIT: begin
        if (alu_done) begin
          state_next = last_step ? wts_pkg::S_FINISH : wts_pkg::S_ISSUE;
        end
      end
      wts_pkg::S_FINISH: begin
        if (out_free) begin
          state_next = wts_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = wts_pkg::S_IDLE;
      end
    endcase
  end

  // operand selection for each step of the calculation
  always_comb begin
    abs_y   = sum_y[SY_W-1] ? (~sum_y + SY_W'(1)) : sum_y;
    n_w     = W'(len);
    nm2_w   = W'(len - LEN_W'(2));
    res_abs = alu_res[WW-1] ? (~alu_res[WW-1:0] + WW'(1)) : alu_res[WW-1:0];
    s_axis_tready = (state == wts_pkg::S_IDLE);
    alu_req.start = (state == wts_pkg::S_ISSUE);
    alu_req.op    = wts_pkg::ALU_MUL;
    alu_a         = t0;
    alu_b         = t1;
    case (step)
      // D = n*Sxx - Sx^2
      wts_pkg::ST_D1: begin alu_a = W'(sum_xx); alu_b = n_w; end
      wts_pkg::ST_D2: begin alu_a = W'(sum_x);  alu_b = W'(sum_x); end
      wts_pkg::ST_D3: begin alu_req.op = wts_pkg::ALU_SUB; end
      // Q = n*Syy - Sy^2
      wts_pkg::ST_Q1: begin alu_a = W'(sum_yy); alu_b = n_w; end
      wts_pkg::ST_Q2: begin alu_a = W'(abs_y);  alu_b = W'(abs_y); end
      wts_pkg::ST_Q3: begin alu_req.op = wts_pkg::ALU_SUB; end
      // Bn = n*Sxy - Sx*Sy
      wts_pkg::ST_B1: begin alu_a = W'(sum_xy); alu_b = n_w; end
      wts_pkg::ST_B2: begin alu_a = W'(sum_y);  alu_b = W'(sum_x); end
      wts_pkg::ST_B3: begin alu_req.op = wts_pkg::ALU_SUB; end
      // An = Sy*Sxx - Sx*Sxy
      wts_pkg::ST_A1: begin alu_a = W'(sum_y);  alu_b = W'(sum_xx); end
      wts_pkg::ST_A2: begin alu_a = W'(sum_xy); alu_b = W'(sum_x); end
      wts_pkg::ST_A3: begin alu_req.op = wts_pkg::ALU_SUB; end
      // R = Q*D - Bn^2
      wts_pkg::ST_R1: begin alu_a = W'(q);  alu_b = W'(d); end
      wts_pkg::ST_R2: begin alu_a = W'(b2); alu_b = W'(b2); end
      wts_pkg::ST_R3: begin alu_req.op = wts_pkg::ALU_SUB; alu_b = b2sq; end
      // intercept: An^2*n*(n-2) / (Sxx*R)
      wts_pkg::ST_N1: begin alu_a = W'(a2); alu_b = W'(a2); end
      wts_pkg::ST_N2: begin alu_b = n_w; end
      wts_pkg::ST_N3: begin alu_b = nm2_w; end
      wts_pkg::ST_N4: begin alu_a = r; alu_b = W'(sum_xx); end
      wts_pkg::ST_N5: begin alu_req.op = wts_pkg::ALU_DIV; end
      wts_pkg::ST_N6: begin alu_req.op = wts_pkg::ALU_SQRT; end
      // slope: Bn^2*(n-2) / R
      wts_pkg::ST_S1: begin alu_a = b2sq; alu_b = nm2_w; end
      wts_pkg::ST_S2: begin alu_req.op = wts_pkg::ALU_DIV; alu_b = r; end
      wts_pkg::ST_S3: begin alu_req.op = wts_pkg::ALU_SQRT; end
      default: begin alu_req.op = wts_pkg::ALU_MUL; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wts_pkg::S_IDLE;
      step  <= wts_pkg::ST_D1;
    end else begin
      state <= state_next;
      if (state == wts_pkg::S_SUMS) begin
        step <= wts_pkg::ST_D1;
      end else if (state == wts_pkg::S_WAIT && alu_done && !last_step) begin
        step <= wts_pkg::calc_step_t'(step + 5'd1);
      end
    end
  end

  // capture of each step's result
  always_ff @(posedge clk) begin
    if (state == wts_pkg::S_WAIT && alu_done) begin
      case (step)
        wts_pkg::ST_D3: d    <= alu_res[WW-1:0];
        wts_pkg::ST_Q3: q    <= alu_res[WW-1:0];
        wts_pkg::ST_B3: b2   <= res_abs;
        wts_pkg::ST_A3: a2   <= res_abs;
        wts_pkg::ST_R2: b2sq <= alu_res;
        wts_pkg::ST_R3: r    <= alu_res;
        wts_pkg::ST_D2, wts_pkg::ST_Q2, wts_pkg::ST_B2, wts_pkg::ST_A2,
        wts_pkg::ST_N4: t1 <= alu_res;
        wts_pkg::ST_N6: it_res <= alu_res[TW-1:0];
        wts_pkg::ST_S3: sl_res <= alu_res[TW-1:0];
        default: t0 <= alu_res;
      endcase
      if (step == wts_pkg::ST_R3) begin
        perfect <= fit_zero;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (state == wts_pkg::S_FINISH && out_free) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tuser  <= perfect;
        m_axis_tdata  <= perfect ? '1 : {sl_res, it_res};
      end
    end
  end

endmodule

// File: design/wts_checker.sv
// Port-level checker of the trend t-statistic block and its bind.
`include "windowed_trend_t_statistic_top_defines.svh"

module wts_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [2*wts_pkg::T_W-1:0]     m_axis_tdata,
  input logic                          m_axis_tuser
);

  // a perfect fit always carries saturated t-values
  `WTS_ASSERT_IMPL(perfect_saturates, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '1)

  // a stalled result item holds
  `WTS_ASSERT_NEXT(out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // reset leaves no result pending and the input side open
  `WTS_ASSERT_RST(reset_clean, !m_axis_tvalid && s_axis_tready)

endmodule

bind windowed_trend_t_statistic_top wts_checker u_wts_checker (.*);

// File: tb/windowed_trend_t_statistic_top_test.sv
// Self-checking testbench for the sliding-window trend t-statistic block.
module windowed_trend_t_statistic_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 6000000;
  localparam int DRAIN_CYCLES = 2000;   // one full-window item on the shared unit, with margin
  localparam int HOLD_CYCLES = 4000;    // long receiver stall for the back-pressure test

  typedef struct {
    logic [wts_pkg::T_W-1:0] intercept_t;
    logic [wts_pkg::T_W-1:0] slope_t;
    logic                    perfect_fit;
  } trend_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [wts_pkg::LEN_CFG_W-1:0] cfg_wdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [wts_pkg::SAMPLE_W-1:0] s_axis_tdata = '0;  // sample
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [2*wts_pkg::T_W-1:0] m_axis_tdata;          // intercept_t, slope_t
  logic m_axis_tuser;                               // perfect_fit

  windowed_trend_t_statistic_top u_top (
    .clk, .rst, .cfg_we, .cfg_wdata,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  // Predictor state: configured window length and the live samples, oldest first.
  int unsigned win_len = wts_pkg::LEN_RESET;
  longint recent_samples[$];
  trend_result_t pending_fits[$];

  int errors = 0;
  int samples_sent = 0;
  int fits_checked = 0;
  int perfect_seen = 0;
  int cycle_count = 0;
  bit idle_on = 1'b1;     // random gaps on both sides
  bit hold_req = 1'b0;    // ask the receiver for one long stall

  initial forever #6 clk = ~clk;

  // Run guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if (!idle_on) return 0;
    if ($urandom_range(99) < 55) return 0;
    if ($urandom_range(99) < 90) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // floor(sqrt(v)) by the usual digit-by-digit method.
  function automatic logic [wts_pkg::T_W-1:0] root_floor(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res[wts_pkg::T_W-1:0];
  endfunction

  // floor(num * 2^32 / den), all ones once the quotient leaves 64 bits.
  function automatic logic [63:0] ratio_q32(logic [127:0] num, logic [127:0] den);
    logic [159:0] quo;
    quo = {num, 32'b0} / {32'b0, den};
    return (|quo[159:64]) ? '1 : quo[63:0];
  endfunction

  // Least-squares trend t-values of the current window.
  function automatic void predict_trend(longint y);
    longint n, sy, sxy, syy, sx, sxx, d, bn, an;
    logic [63:0] q, b2, a2;
    logic [127:0] rss_n, num, den;
    trend_result_t fit;
    recent_samples.push_back(y);
    if (recent_samples.size() > win_len) void'(recent_samples.pop_front());
    if (recent_samples.size() < win_len) return;
    n = win_len;
    sy = 0; sxy = 0; syy = 0;
    foreach (recent_samples[k]) begin
      sy += recent_samples[k];
      sxy += (k + 1) * recent_samples[k];
      syy += recent_samples[k] * recent_samples[k];
    end
    sx = n * (n + 1) / 2;
    sxx = n * (n + 1) * (2 * n + 1) / 6;
    d = n * sxx - sx * sx;
    q = n * syy - sy * sy;
    bn = n * sxy - sx * sy;
    an = sy * sxx - sx * sxy;
    b2 = bn < 0 ? -bn : bn;
    a2 = an < 0 ? -an : an;
    rss_n = 128'(q) * 128'(d) - 128'(b2) * 128'(b2);
    if (rss_n == 0) begin
      fit.intercept_t = '1;
      fit.slope_t = '1;
      fit.perfect_fit = 1'b1;
    end else begin
      num = 128'(a2) * 128'(a2) * 128'(n) * 128'(n - 2);
      den = rss_n * 128'(sxx);
      fit.intercept_t = root_floor(ratio_q32(num, den));
      num = 128'(b2) * 128'(b2) * 128'(n - 2);
      fit.slope_t = root_floor(ratio_q32(num, rss_n));
      fit.perfect_fit = 1'b0;
    end
    pending_fits.push_back(fit);
  endfunction

  // Sends one item; entered and left at a falling edge.
  task automatic send_sample(logic signed [wts_pkg::SAMPLE_W-1:0] s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= s;
    do @(posedge clk); while (!s_axis_tready);
    predict_trend(longint'(s));
    samples_sent++;
    @(negedge clk);
  endtask

  // Waits for all expected results plus the block's worst-case latency.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_fits.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_window_len(logic [wts_pkg::LEN_CFG_W-1:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    win_len = v < wts_pkg::LEN_MIN ? wts_pkg::LEN_MIN :
              (v > wts_pkg::WINDOW_MAX_DEF ? wts_pkg::WINDOW_MAX_DEF : v);
    recent_samples.delete();
  endtask

  function automatic logic signed [wts_pkg::SAMPLE_W-1:0] random_sample();
    case ($urandom_range(3))
      0: return wts_pkg::SAMPLE_W'($urandom);          // full range
      1: return $signed(wts_pkg::SAMPLE_W'($urandom_range(511))) - wts_pkg::SAMPLE_W'(256);
      2: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      default: return $signed(wts_pkg::SAMPLE_W'($urandom_range(65535)))
                      - wts_pkg::SAMPLE_W'(32768);
    endcase
  endfunction

  // Receiver: random stalls, plus one long counted hold when asked.
  initial begin
    int stall;
    int held;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      @(negedge clk);
    end
  end

  // Result checker: every accepted item against the oldest prediction.
  always @(posedge clk) begin
    trend_result_t exp_fit;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_fits.size() == 0) begin
        $display("%0t unexpected result item %h/%b", $time, m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        exp_fit = pending_fits.pop_front();
        fits_checked++;
        if (exp_fit.perfect_fit) perfect_seen++;
        if (m_axis_tdata[wts_pkg::T_W-1:0] !== exp_fit.intercept_t) begin
          $display("%0t intercept_t exp %h got %h", $time, exp_fit.intercept_t,
                   m_axis_tdata[wts_pkg::T_W-1:0]);
          errors++;
        end
        if (m_axis_tdata[2*wts_pkg::T_W-1:wts_pkg::T_W] !== exp_fit.slope_t) begin
          $display("%0t slope_t exp %h got %h", $time, exp_fit.slope_t,
                   m_axis_tdata[2*wts_pkg::T_W-1:wts_pkg::T_W]);
          errors++;
        end
        if (m_axis_tuser !== exp_fit.perfect_fit) begin
          $display("%0t perfect_fit exp %b got %b", $time, exp_fit.perfect_fit, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // Constant, ramp and all-zero windows: zero residual.
  task automatic test_perfect_fits();
    write_window_len(3);
    repeat (4) send_sample(24'sd1000);
    for (int k = 0; k < 4; k++) send_sample(-24'sd500 + 24'(k * 77));
    repeat (3) send_sample('0);
  endtask

  // Zero slope and zero intercept with a nonzero residual; field extremes.
  task automatic test_special_cases();
    write_window_len(3);
    send_sample(0); send_sample(256); send_sample(0);        // flat trend, bump in middle
    write_window_len(3);
    send_sample(1); send_sample(0); send_sample(2);          // line through the origin
    write_window_len(4);
    send_sample(24'h7FFFFF); send_sample(24'h800000);
    send_sample(24'h7FFFFF); send_sample(24'h800000); send_sample(24'h7FFFFF);
  endtask

  // Out-of-range lengths clamp; every bit of the written value toggles.
  task automatic test_length_clamp();
    write_window_len(0);
    repeat (4) send_sample(random_sample());
    write_window_len(127);
    repeat (66) send_sample(random_sample());
    write_window_len(1);
    repeat (4) send_sample(random_sample());
  endtask

  // Receiver stalls for a long stretch while samples keep coming.
  task automatic test_backpressure();
    write_window_len(3);
    hold_req = 1'b1;
    repeat (20) send_sample(random_sample());
  endtask

  // Random phases, mostly short windows, one full-length window.
  task automatic test_random_windows();
    int len;
    for (int ph = 0; ph < 12; ph++) begin
      len = (ph == 5) ? wts_pkg::WINDOW_MAX_DEF : (ph == 9 ? 2 : $urandom_range(12, 3));
      write_window_len(wts_pkg::LEN_CFG_W'(len));
      idle_on = (ph % 4) != 3;
      repeat ((ph == 5) ? 150 : 105) send_sample(random_sample());
    end
    idle_on = 1'b1;
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_perfect_fits();
    test_special_cases();
    test_length_clamp();
    test_backpressure();
    test_random_windows();
    wait_idle();
    $display("Sent %0d samples, checked %0d trend results (%0d zero-residual),",
             samples_sent, fits_checked, perfect_seen);
    $display("window lengths 3..64 incl. clamped writes and a long output stall.");
    if (errors == 0 && pending_fits.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_fits.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
